// File: rtl/bitplane_block_move_rop_macros.svh
// assertion macros for the block move plane
`ifndef BITPLANE_BLOCK_MOVE_ROP_MACROS_SVH
`define BITPLANE_BLOCK_MOVE_ROP_MACROS_SVH
// implication checked on every edge outside reset
`define BBM_ASSERT_IMP(label, clk, rst_n, a, b) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
    else $error("assertion failed");
// next-cycle implication
`define BBM_ASSERT_NEXT(label, clk, rst_n, a, b) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
    else $error("assertion failed");
`endif

// File: rtl/bbm_pkg.sv
// ----------------------------------------------------------------------------
// bbm_pkg
// types, constants and rule helper for the bit plane block mover
// ----------------------------------------------------------------------------
package bbm_pkg;

  localparam int unsigned FbWidth  = 1024;
  localparam int unsigned FbHeight = 1024;
  localparam int unsigned XW = $clog2(FbWidth);
  localparam int unsigned YW = $clog2(FbHeight);
  localparam int unsigned AW = XW + YW;
  localparam int unsigned Depth = FbWidth * FbHeight;
  localparam int unsigned CW = 11;
  localparam logic [3:0] RuleMask = 4'h0f;
  localparam logic [3:0] RuleReset = 4'd3;
  localparam int unsigned QDepth = 2;
  localparam int unsigned QPtrW = $clog2(QDepth);

  typedef enum logic [1:0] {
    FUNC_WRITE = 2'd0,
    FUNC_READ  = 2'd1,
    FUNC_MOVE  = 2'd2,
    FUNC_NONE  = 2'd3
  } func_e;

  typedef enum logic [2:0] {
    REG_SRC_X = 3'd0, REG_SRC_Y = 3'd1, REG_DST_X = 3'd2, REG_DST_Y = 3'd3,
    REG_WIDTH = 3'd4, REG_HEIGHT = 3'd5, REG_RULE = 3'd6, REG_ENABLE = 3'd7
  } reg_e;

  typedef enum logic [1:0] {
    OP_WRITE = 2'd0, OP_READ = 2'd1, OP_MOVE = 2'd2, OP_NOP = 2'd3
  } op_e;

  typedef enum logic [2:0] {
    ST_CLEAR, ST_IDLE, ST_RD_SRC, ST_RD_DST, ST_WR, ST_PIX, ST_OUT
  } state_e;

  typedef struct packed {
    logic [1:0] func;
    logic [9:0] pixel_x;
    logic [9:0] pixel_y;
    logic       pixel_value;
  } in_word_t;

  typedef struct packed {
    logic read_value;
    logic move_done;
  } out_word_t;

  // classified command passed from front to back
  typedef struct packed {
    op_e        op;
    logic       in_plane;
    logic [AW-1:0] addr;
    logic       value;
  } cmd_t;

  typedef struct packed {
    logic [9:0] src_x;
    logic [9:0] src_y;
    logic [9:0] dst_x;
    logic [9:0] dst_y;
    logic [10:0] width;
    logic [10:0] height;
    logic [3:0] rule;
    logic       enable;
  } cfg_t;

  function automatic logic apply_rule(logic [3:0] rule, logic s, logic d);
    logic [1:0] sel;
    logic [3:0] r;
    sel = {~s, ~d};
    r = rule & RuleMask;
    return r[sel];
  endfunction

endpackage

// File: rtl/bitplane_block_move_rop.sv
// ----------------------------------------------------------------------------
// bitplane_block_move_rop
// one bit plane with pixel access and raster-rule block moves
// ----------------------------------------------------------------------------
// channel   direction  handshake            payload
// in        input      in_valid/in_ready    bbm_pkg::in_word_t
// out       output     out_valid/out_ready  bbm_pkg::out_word_t
// cfg       input      cfg_we               cfg_index, cfg_wdata
//
// pixel read, write, disabled or empty move: idle, pixel and output states
// block move: source read, destination read and write states per pixel on the plane memory, then the output state
// after reset the plane is cleared one pixel a cycle, all 1048576 pixels
// a two-entry command queue lets words come in while the back end stalls
// ----------------------------------------------------------------------------
`include "bitplane_block_move_rop_macros.svh"

module bitplane_block_move_rop (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  bbm_pkg::in_word_t  in_data_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output bbm_pkg::out_word_t out_data_o,
  input  logic               cfg_we_i,
  input  logic [2:0]         cfg_index_i,
  input  logic [10:0]        cfg_wdata_i
);

  bbm_pkg::cfg_t cfg_q;
  logic cmd_valid, cmd_ready, busy;
  bbm_pkg::cmd_t cmd;

  // configuration registers, rule resets to copy
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.src_x  <= '0;
      cfg_q.src_y  <= '0;
      cfg_q.dst_x  <= '0;
      cfg_q.dst_y  <= '0;
      cfg_q.width  <= '0;
      cfg_q.height <= '0;
      cfg_q.rule   <= bbm_pkg::RuleReset;
      cfg_q.enable <= 1'b0;
    end else if (cfg_we_i) begin
      case (bbm_pkg::reg_e'(cfg_index_i))
        bbm_pkg::REG_SRC_X:  cfg_q.src_x  <= cfg_wdata_i[9:0];
        bbm_pkg::REG_SRC_Y:  cfg_q.src_y  <= cfg_wdata_i[9:0];
        bbm_pkg::REG_DST_X:  cfg_q.dst_x  <= cfg_wdata_i[9:0];
        bbm_pkg::REG_DST_Y:  cfg_q.dst_y  <= cfg_wdata_i[9:0];
        bbm_pkg::REG_WIDTH:  cfg_q.width  <= cfg_wdata_i;
        bbm_pkg::REG_HEIGHT: cfg_q.height <= cfg_wdata_i;
        bbm_pkg::REG_RULE:   cfg_q.rule   <= cfg_wdata_i[3:0];
        bbm_pkg::REG_ENABLE: cfg_q.enable <= cfg_wdata_i[0];
        default: ;
      endcase
    end
  end

  // front: classify and queue
  bbm_front u_front (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .in_data_i,
    .move_enable_i(cfg_q.enable),
    .cmd_valid_o(cmd_valid), .cmd_ready_i(cmd_ready), .cmd_o(cmd)
  );

  // back: memory walk and result
  bbm_back u_back (
    .clk_i, .rst_ni,
    .cmd_valid_i(cmd_valid), .cmd_ready_o(cmd_ready), .cmd_i(cmd),
    .cfg_i(cfg_q), .out_valid_o, .out_ready_i, .out_data_o, .busy_o(busy)
  );

  `BBM_ASSERT_IMP(a_pop_idle, clk_i, rst_ni, cmd_valid && cmd_ready, !busy)
  `BBM_ASSERT_IMP(a_out_busy, clk_i, rst_ni, out_valid_o, busy)
  `BBM_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_o && !out_ready_i,
                   out_valid_o && $stable(out_data_o))

endmodule

// File: rtl/bbm_front.sv
// ----------------------------------------------------------------------------
// bbm_front
// accepts input words, classifies them and queues commands
// ----------------------------------------------------------------------------
module bbm_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  bbm_pkg::in_word_t in_data_i,
  input  logic              move_enable_i,
  output logic              cmd_valid_o,
  input  logic              cmd_ready_i,
  output bbm_pkg::cmd_t     cmd_o
);

  bbm_pkg::cmd_t q_mem_q [bbm_pkg::QDepth];
  logic [bbm_pkg::QPtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [bbm_pkg::QPtrW:0]   count_q;
  bbm_pkg::cmd_t cmd_new;
  logic push, pop;

  always_comb begin
    cmd_new.in_plane = (32'(in_data_i.pixel_x) < bbm_pkg::FbWidth) &&
                       (32'(in_data_i.pixel_y) < bbm_pkg::FbHeight);
    cmd_new.addr  = {in_data_i.pixel_y[bbm_pkg::YW-1:0],
                     in_data_i.pixel_x[bbm_pkg::XW-1:0]};
    cmd_new.value = in_data_i.pixel_value;
    case (bbm_pkg::func_e'(in_data_i.func))
      bbm_pkg::FUNC_WRITE: cmd_new.op = bbm_pkg::OP_WRITE;
      bbm_pkg::FUNC_READ:  cmd_new.op = bbm_pkg::OP_READ;
      bbm_pkg::FUNC_MOVE:  cmd_new.op = move_enable_i ? bbm_pkg::OP_MOVE : bbm_pkg::OP_NOP;
      default:             cmd_new.op = bbm_pkg::OP_NOP;
    endcase
  end

  assign in_ready_o  = count_q < (bbm_pkg::QPtrW+1)'(bbm_pkg::QDepth);
  assign cmd_valid_o = count_q != '0;
  assign cmd_o       = q_mem_q[rd_ptr_q];
  assign push = in_valid_i && in_ready_o;
  assign pop  = cmd_valid_o && cmd_ready_i;

  always_ff @(posedge clk_i) begin
    if (push) q_mem_q[wr_ptr_q] <= cmd_new;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push) wr_ptr_q <= wr_ptr_q + 1'b1;
      if (pop)  rd_ptr_q <= rd_ptr_q + 1'b1;
      count_q <= count_q + (bbm_pkg::QPtrW+1)'(push) - (bbm_pkg::QPtrW+1)'(pop);
    end
  end

endmodule

// File: rtl/bbm_back.sv
// ----------------------------------------------------------------------------
// bbm_back
// runs pixel accesses and block moves against the plane memory
// ----------------------------------------------------------------------------
module bbm_back (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cmd_valid_i,
  output logic               cmd_ready_o,
  input  bbm_pkg::cmd_t      cmd_i,
  input  bbm_pkg::cfg_t      cfg_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output bbm_pkg::out_word_t out_data_o,
  output logic               busy_o
);

  logic mem_q [bbm_pkg::Depth];
  logic rd_data_q;

  bbm_pkg::state_e state_q, state_d;
  logic [bbm_pkg::AW-1:0] clr_q, clr_d;
  logic [10:0] r_q, r_d, c_q, c_d;
  logic src_q, src_d;
  bbm_pkg::op_e op_q, op_d;
  logic inside_q, inside_d;
  bbm_pkg::out_word_t res_q, res_d;

  logic [10:0] row, col;
  logic [11:0] sx, sy, dx, dy;
  logic s_in, d_in;
  logic last_c, last_r, empty;
  logic mem_we, mem_wd;
  logic [bbm_pkg::AW-1:0] mem_wa, mem_ra;

  always_comb begin
    row = (cfg_i.dst_y > cfg_i.src_y) ? cfg_i.height - 11'd1 - r_q : r_q;
    col = (cfg_i.dst_x > cfg_i.src_x) ? cfg_i.width - 11'd1 - c_q : c_q;
    sx = 12'(cfg_i.src_x) + 12'(col);
    sy = 12'(cfg_i.src_y) + 12'(row);
    dx = 12'(cfg_i.dst_x) + 12'(col);
    dy = 12'(cfg_i.dst_y) + 12'(row);
    s_in = (32'(sx) < bbm_pkg::FbWidth) && (32'(sy) < bbm_pkg::FbHeight);
    d_in = (32'(dx) < bbm_pkg::FbWidth) && (32'(dy) < bbm_pkg::FbHeight);
    last_c = c_q == cfg_i.width - 11'd1;
    last_r = r_q == cfg_i.height - 11'd1;
    empty = (cfg_i.width == '0) || (cfg_i.height == '0);
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      bbm_pkg::ST_CLEAR: if (&clr_q) state_d = bbm_pkg::ST_IDLE;
      bbm_pkg::ST_IDLE: if (cmd_valid_i) begin
        if (cmd_i.op == bbm_pkg::OP_MOVE && !empty) state_d = bbm_pkg::ST_RD_SRC;
        else state_d = bbm_pkg::ST_PIX;
      end
      bbm_pkg::ST_RD_SRC: state_d = bbm_pkg::ST_RD_DST;
      bbm_pkg::ST_RD_DST: state_d = bbm_pkg::ST_WR;
      bbm_pkg::ST_WR: state_d = (last_c && last_r) ? bbm_pkg::ST_OUT : bbm_pkg::ST_RD_SRC;
      bbm_pkg::ST_PIX: state_d = bbm_pkg::ST_OUT;
      bbm_pkg::ST_OUT: if (out_ready_i) state_d = bbm_pkg::ST_IDLE;
      default: state_d = bbm_pkg::ST_IDLE;
    endcase
  end

  // outputs and datapath
  always_comb begin
    clr_d = clr_q; r_d = r_q; c_d = c_q; src_d = src_q;
    op_d = op_q; inside_d = inside_q; res_d = res_q;
    mem_we = 1'b0; mem_wa = '0; mem_wd = 1'b0; mem_ra = '0;
    cmd_ready_o = 1'b0;
    case (state_q)
      bbm_pkg::ST_CLEAR: begin
        mem_we = 1'b1; mem_wa = clr_q; clr_d = clr_q + 1'b1;
      end
      bbm_pkg::ST_IDLE: begin
        cmd_ready_o = 1'b1;
        mem_ra = cmd_i.addr;
        if (cmd_valid_i) begin
          op_d = cmd_i.op; inside_d = cmd_i.in_plane;
          r_d = '0; c_d = '0;
          mem_we = (cmd_i.op == bbm_pkg::OP_WRITE) && cmd_i.in_plane;
          mem_wa = cmd_i.addr; mem_wd = cmd_i.value;
        end
      end
      bbm_pkg::ST_RD_SRC: mem_ra = {sy[bbm_pkg::YW-1:0], sx[bbm_pkg::XW-1:0]};
      bbm_pkg::ST_RD_DST: begin
        mem_ra = {dy[bbm_pkg::YW-1:0], dx[bbm_pkg::XW-1:0]};
        src_d = rd_data_q && s_in;
      end
      bbm_pkg::ST_WR: begin
        mem_we = d_in;
        mem_wa = {dy[bbm_pkg::YW-1:0], dx[bbm_pkg::XW-1:0]};
        mem_wd = bbm_pkg::apply_rule(cfg_i.rule, src_q, rd_data_q && d_in);
        if (last_c) begin c_d = '0; r_d = r_q + 11'd1; end
        else c_d = c_q + 11'd1;
        res_d.read_value = 1'b0; res_d.move_done = 1'b1;
      end
      bbm_pkg::ST_PIX: begin
        res_d.read_value = (op_q == bbm_pkg::OP_READ) && inside_q && rd_data_q;
        res_d.move_done  = op_q == bbm_pkg::OP_MOVE;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) mem_q[mem_wa] <= mem_wd;
    rd_data_q <= mem_q[mem_ra];
  end

  always_ff @(posedge clk_i) begin
    r_q <= r_d; c_q <= c_d; src_q <= src_d;
    op_q <= op_d; inside_q <= inside_d; res_q <= res_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= bbm_pkg::ST_CLEAR;
      clr_q   <= '0;
    end else begin
      state_q <= state_d;
      clr_q   <= clr_d;
    end
  end

  assign out_valid_o = state_q == bbm_pkg::ST_OUT;
  assign out_data_o  = res_q;
  assign busy_o      = state_q != bbm_pkg::ST_IDLE;

endmodule

// File: tb/sv/bitplane_block_move_rop_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// bitplane_block_move_rop_tb
// drives pixel writes, reads and block moves through the valid/ready input
// channel, predicts result words from an internal copy of the bit plane and
// its registers or takes typed ones from the table, compares field by field
// ----------------------------------------------------------------------------
module bitplane_block_move_rop_tb;

  localparam int unsigned PlaneW = 1024;
  localparam int unsigned PlaneH = 1024;
  // the limit must cover the clear pass after reset, which writes every pixel
  localparam int unsigned StallLimit = 3000000;
  localparam int unsigned Phases = 20;
  localparam int unsigned WordsPerPhase = 50;

  typedef struct {
    bit                 is_cfg;
    bbm_pkg::reg_e      idx;
    logic [10:0]        val;
    bbm_pkg::in_word_t  word;
    bit                 typed;
    bbm_pkg::out_word_t want;
  } row_t;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_ready_o;
  bbm_pkg::in_word_t  in_data = '0;
  logic               out_valid_o;
  logic               out_ready = 1'b0;
  bbm_pkg::out_word_t out_data_o;
  logic               cfg_we = 1'b0;
  logic [2:0]         cfg_index = '0;
  logic [10:0]        cfg_wdata = '0;

  // typed expectation travels with the word it belongs to
  logic               in_typed = 1'b0;
  bbm_pkg::out_word_t in_typed_want = '0;

  // predictor state: plane copy and register copy
  bit                 plane_model [PlaneW*PlaneH];
  int unsigned        m_src_x, m_src_y, m_dst_x, m_dst_y;
  int unsigned        m_width, m_height, m_rule, m_enable;

  bbm_pkg::out_word_t pending_results[$];
  row_t               directed_rows[$];
  int unsigned        fail_cnt = 0;
  int unsigned        stall_cnt = 0;
  bit                 idle_on = 1'b1;
  bit                 hold_req = 1'b0;

  bitplane_block_move_rop i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready),
    .out_data_o  (out_data_o),
    .cfg_we_i    (cfg_we),
    .cfg_index_i (cfg_index),
    .cfg_wdata_i (cfg_wdata)
  );

  initial begin
    forever #4 clk_i = ~clk_i;
  end

  task automatic report(input string msg);
    $display("mismatch at %0t: %s", $realtime, msg);
    fail_cnt++;
  endtask

  // ---------------------------------------------------------------------------
  // predictor
  // ---------------------------------------------------------------------------
  function automatic bit pixel_at(int unsigned x, int unsigned y);
    if (x >= PlaneW || y >= PlaneH) return 1'b0;
    return plane_model[y*PlaneW + x];
  endfunction

  function automatic void pixel_set(int unsigned x, int unsigned y, bit v);
    if (x >= PlaneW || y >= PlaneH) return;  // off-plane writes are dropped
    plane_model[y*PlaneW + x] = v;
  endfunction

  function automatic bbm_pkg::out_word_t predict_word(bbm_pkg::in_word_t w);
    bbm_pkg::out_word_t res;
    bit                 down, right, s, d;
    int unsigned        row, col;
    logic [1:0]         sel;
    logic [3:0]         rule;
    res = '0;
    case (bbm_pkg::func_e'(w.func))
      bbm_pkg::FUNC_WRITE: pixel_set(32'(w.pixel_x), 32'(w.pixel_y), w.pixel_value);
      bbm_pkg::FUNC_READ:  res.read_value = pixel_at(32'(w.pixel_x), 32'(w.pixel_y));
      bbm_pkg::FUNC_MOVE: begin
        if (m_enable != 0) begin
          // walk away from the overlap so sources are read before overwrite
          down  = m_dst_y > m_src_y;
          right = m_dst_x > m_src_x;
          rule  = m_rule[3:0];
          for (int unsigned r = 0; r < m_height; r++) begin
            row = down ? (m_height - 1 - r) : r;
            for (int unsigned c = 0; c < m_width; c++) begin
              col = right ? (m_width - 1 - c) : c;
              s = pixel_at(m_src_x + col, m_src_y + row);
              d = pixel_at(m_dst_x + col, m_dst_y + row);
              sel = {~s, ~d};
              pixel_set(m_dst_x + col, m_dst_y + row, rule[sel]);
            end
          end
          res.move_done = 1'b1;
        end
      end
      default: ;  // unused func: no effect, zero result
    endcase
    return res;
  endfunction

  // ---------------------------------------------------------------------------
  // monitor: predict on input accept, compare on output accept, watchdog
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin
    bbm_pkg::out_word_t want;
    bbm_pkg::out_word_t got;
    if (rst_ni) begin
      if (in_valid && in_ready_o) begin
        want = predict_word(in_data);
        pending_results.push_back(in_typed ? in_typed_want : want);
      end
      if (out_valid_o && out_ready) begin
        got = out_data_o;
        if (pending_results.size() == 0) begin
          report("result word with nothing expected");
        end else begin
          want = pending_results.pop_front();
          if (got.read_value !== want.read_value)
            report($sformatf("read_value got %b want %b", got.read_value,
                             want.read_value));
          if (got.move_done !== want.move_done)
            report($sformatf("move_done got %b want %b", got.move_done,
                             want.move_done));
        end
      end
      if ((in_valid && in_ready_o) || (out_valid_o && out_ready)) begin
        stall_cnt <= 0;
      end else if (stall_cnt >= StallLimit) begin
        $display("timeout: no handshake for %0d cycles", stall_cnt);
        $display("bitplane_block_move_rop_tb failed");
        $finish;
      end else begin
        stall_cnt <= stall_cnt + 1;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // receiver: random stalls, one long hold-off on request
  // ---------------------------------------------------------------------------
  initial begin
    @(posedge rst_ni);
    forever begin
      if (hold_req) begin
        out_ready <= 1'b0;
        repeat (300) @(posedge clk_i);
        hold_req = 1'b0;
      end else if (idle_on && $urandom_range(0, 3) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 14)) @(posedge clk_i);
      end else begin
        out_ready <= 1'b1;
        repeat ($urandom_range(1, 20)) @(posedge clk_i);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // sender helpers
  // ---------------------------------------------------------------------------
  // valid stays high between back-to-back words; this task drops it only for a gap
  task automatic send_word(input bbm_pkg::in_word_t w, input bit typed,
                           input bbm_pkg::out_word_t want);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 14)) @(posedge clk_i);
    end
    in_valid      <= 1'b1;
    in_data       <= w;
    in_typed      <= typed;
    in_typed_want <= want;
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  // stop offering words and wait for every result word
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk_i);
    while (pending_results.size() != 0) @(posedge clk_i);
    // no item ends without a result word, so the block is idle now
    repeat (4) @(posedge clk_i);
  endtask

  // block must be idle; model copy is updated along with the write
  task automatic write_reg(input bbm_pkg::reg_e idx, input logic [10:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk_i);
    case (idx)
      bbm_pkg::REG_SRC_X:  m_src_x  = 32'(val[9:0]);
      bbm_pkg::REG_SRC_Y:  m_src_y  = 32'(val[9:0]);
      bbm_pkg::REG_DST_X:  m_dst_x  = 32'(val[9:0]);
      bbm_pkg::REG_DST_Y:  m_dst_y  = 32'(val[9:0]);
      bbm_pkg::REG_WIDTH:  m_width  = 32'(val);
      bbm_pkg::REG_HEIGHT: m_height = 32'(val);
      bbm_pkg::REG_RULE:   m_rule   = 32'(val[3:0]);
      bbm_pkg::REG_ENABLE: m_enable = 32'(val[0]);
      default: ;
    endcase
  endtask

  function automatic bbm_pkg::in_word_t mk_word(bbm_pkg::func_e f, int unsigned x,
                                                int unsigned y, bit v);
    bbm_pkg::in_word_t w;
    w.func = f;
    w.pixel_x = x[9:0];
    w.pixel_y = y[9:0];
    w.pixel_value = v;
    return w;
  endfunction

  function automatic void add_item(bbm_pkg::func_e f, int unsigned x, int unsigned y,
                                   bit v, bit typed, bit rd, bit done);
    row_t r;
    r.is_cfg = 1'b0;
    r.idx = bbm_pkg::REG_SRC_X;
    r.val = '0;
    r.word = mk_word(f, x, y, v);
    r.typed = typed;
    r.want.read_value = rd;
    r.want.move_done = done;
    directed_rows.push_back(r);
  endfunction

  function automatic void add_cfg(bbm_pkg::reg_e idx, logic [10:0] val);
    row_t r;
    r.is_cfg = 1'b1;
    r.idx = idx;
    r.val = val;
    r.word = '0;
    r.typed = 1'b0;
    r.want = '0;
    directed_rows.push_back(r);
  endfunction

  // coordinates mostly in two small windows so reads hit written pixels
  function automatic int unsigned rand_coord();
    int unsigned pick;
    pick = $urandom_range(0, 9);
    if (pick < 5) return $urandom_range(0, 40);
    if (pick < 8) return $urandom_range(990, 1023);
    return $urandom_range(0, 1023);
  endfunction

  // ---------------------------------------------------------------------------
  // main sequence
  // ---------------------------------------------------------------------------
  initial begin
    row_t              r;
    bbm_pkg::in_word_t w;
    int unsigned       pick;
    int unsigned       fsel;
    logic [10:0]       wd, ht;

    foreach (plane_model[i]) plane_model[i] = 1'b0;
    m_src_x = 0; m_src_y = 0; m_dst_x = 0; m_dst_y = 0;
    m_width = 0; m_height = 0; m_rule = 32'(bbm_pkg::RuleReset); m_enable = 0;

    // directed table: typed results only where obvious
    add_item(bbm_pkg::FUNC_READ,  0,    0,    1'b0, 1'b1, 1'b0, 1'b0);  // cleared
    add_item(bbm_pkg::FUNC_READ,  1023, 1023, 1'b0, 1'b1, 1'b0, 1'b0);
    add_item(bbm_pkg::FUNC_WRITE, 1023, 1023, 1'b1, 1'b1, 1'b0, 1'b0);
    add_item(bbm_pkg::FUNC_READ,  1023, 1023, 1'b0, 1'b1, 1'b1, 1'b0);
    add_item(bbm_pkg::FUNC_WRITE, 0,    0,    1'b1, 1'b1, 1'b0, 1'b0);
    add_item(bbm_pkg::FUNC_READ,  0,    0,    1'b0, 1'b1, 1'b1, 1'b0);
    add_item(bbm_pkg::FUNC_MOVE,  5,    5,    1'b1, 1'b1, 1'b0, 1'b0);  // disabled
    add_item(bbm_pkg::FUNC_NONE,  1023, 1023, 1'b1, 1'b1, 1'b0, 1'b0);  // unused func
    add_cfg(bbm_pkg::REG_ENABLE, 11'd1);
    add_item(bbm_pkg::FUNC_MOVE,  0,    0,    1'b0, 1'b1, 1'b0, 1'b1);  // empty move
    // overlapping xor move down and right
    add_cfg(bbm_pkg::REG_WIDTH, 11'd4);
    add_cfg(bbm_pkg::REG_HEIGHT, 11'd4);
    add_cfg(bbm_pkg::REG_DST_X, 11'd2);
    add_cfg(bbm_pkg::REG_DST_Y, 11'd1);
    add_cfg(bbm_pkg::REG_RULE, 11'd6);
    add_item(bbm_pkg::FUNC_MOVE,  0,    0,    1'b0, 1'b1, 1'b0, 1'b1);
    add_item(bbm_pkg::FUNC_READ,  2,    1,    1'b0, 1'b0, 1'b0, 1'b0);
    // set rule straddling the bottom-right corner
    add_cfg(bbm_pkg::REG_SRC_X, 11'd1023);
    add_cfg(bbm_pkg::REG_SRC_Y, 11'd1023);
    add_cfg(bbm_pkg::REG_DST_X, 11'd1022);
    add_cfg(bbm_pkg::REG_DST_Y, 11'd1022);
    add_cfg(bbm_pkg::REG_RULE, 11'd15);
    add_item(bbm_pkg::FUNC_MOVE,  0,    0,    1'b0, 1'b1, 1'b0, 1'b1);
    add_item(bbm_pkg::FUNC_READ,  1022, 1023, 1'b0, 1'b1, 1'b1, 1'b0);
    // oversized width, clear rule, one row
    add_cfg(bbm_pkg::REG_WIDTH, 11'd2047);
    add_cfg(bbm_pkg::REG_HEIGHT, 11'd1);
    add_cfg(bbm_pkg::REG_RULE, 11'd0);
    add_item(bbm_pkg::FUNC_MOVE,  0,    0,    1'b0, 1'b1, 1'b0, 1'b1);
    add_item(bbm_pkg::FUNC_READ,  1023, 1022, 1'b0, 1'b1, 1'b0, 1'b0);

    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;

    foreach (directed_rows[i]) begin
      r = directed_rows[i];
      if (r.is_cfg) begin
        drain();
        write_reg(r.idx, r.val);
        cfg_we <= 1'b0;
      end else begin
        send_word(r.word, r.typed, r.want);
      end
    end

    // random phases: fresh registers, then a burst of words
    for (int unsigned ph = 0; ph < Phases; ph++) begin
      drain();
      if (ph >= Phases - 4) idle_on = 1'b0;  // last stretch runs flat out
      pick = $urandom_range(0, 9);
      if (pick < 8) begin
        wd = 11'($urandom_range(0, 10));
        ht = 11'($urandom_range(0, 10));
      end else if (pick == 8) begin
        wd = ($urandom_range(0, 1) != 0) ? 11'd2047 : 11'd1024;
        ht = 11'($urandom_range(0, 1));
      end else begin
        wd = 11'($urandom_range(0, 1));
        ht = ($urandom_range(0, 1) != 0) ? 11'd2047 : 11'd1024;
      end
      write_reg(bbm_pkg::REG_SRC_X, 11'(rand_coord()));
      write_reg(bbm_pkg::REG_SRC_Y, 11'(rand_coord()));
      write_reg(bbm_pkg::REG_DST_X, 11'(rand_coord()));
      write_reg(bbm_pkg::REG_DST_Y, 11'(rand_coord()));
      write_reg(bbm_pkg::REG_WIDTH, wd);
      write_reg(bbm_pkg::REG_HEIGHT, ht);
      write_reg(bbm_pkg::REG_RULE, 11'($urandom_range(0, 15)));
      write_reg(bbm_pkg::REG_ENABLE, ($urandom_range(0, 4) != 0) ? 11'd1 : 11'd0);
      cfg_we <= 1'b0;

      if (ph == 5) hold_req = 1'b1;  // receiver holds off, input backs up

      for (int unsigned k = 0; k < WordsPerPhase; k++) begin
        fsel = $urandom_range(0, 19);
        if (fsel < 8)       w.func = bbm_pkg::FUNC_WRITE;
        else if (fsel < 15) w.func = bbm_pkg::FUNC_READ;
        else if (fsel < 19) w.func = bbm_pkg::FUNC_MOVE;
        else                w.func = bbm_pkg::FUNC_NONE;
        w.pixel_x = 10'(rand_coord());
        w.pixel_y = 10'(rand_coord());
        w.pixel_value = 1'($urandom_range(0, 1));
        send_word(w, 1'b0, '0);
      end
    end

    drain();
    repeat (20) @(posedge clk_i);
    if (fail_cnt == 0) begin
      $display("bitplane_block_move_rop_tb passed");
    end else begin
      $display("bitplane_block_move_rop_tb failed");
    end
    $finish;
  end

endmodule

// File: filelist.f
+incdir+rtl
rtl/bbm_pkg.sv
rtl/bbm_front.sv
rtl/bbm_back.sv
rtl/bitplane_block_move_rop.sv
tb/sv/bitplane_block_move_rop_tb.sv
